FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared types, character codes and default geometry for the console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Default screen geometry.
   localparam int TCW_COLUMNS = 80;
   localparam int TCW_ROWS    = 25;

   // Fixed field widths of the request and response channels.
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;

   // Action codes carried in a request.
   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Character codes with a special meaning.
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

   // A blank cell is a space with light gray on black.
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h07;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DONE
   } tcw_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic exec;
      logic scroll_step;
      logic finish;
   } tcw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic wrap;
      logic count_last;
      logic rsp_free;
   } tcw_status_type;

endpackage

FILE: design/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console cell writer channels
// Valid/ready channels for requests into the writer and responses out of it.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [CHAR_W-1:0]  char_code;
   logic [CHAR_W-1:0]  attr_byte;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, action, char_code, attr_byte, cell_index, input ready);
   modport sink   (input valid, action, char_code, attr_byte, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] cursor_pos;
   logic [CHAR_W-1:0]  cell_char;
   logic [CHAR_W-1:0]  cell_attr;
   logic               scrolled;

   modport source (output valid, cursor_pos, cell_char, cell_attr, scrolled, input ready);
   modport sink   (input valid, cursor_pos, cell_char, cell_attr, scrolled, output ready);
endinterface

FILE: design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console cell writer controller
// Sequences the clearing pass, request handling, scroll sweep and response.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   tcw_state_type state_ff;
   tcw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.count_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.wrap ? ST_SCROLL : ST_DONE;
         end
         ST_SCROLL: begin
            if (status.count_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = req_valid ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.finish  = 1'b1;
               req_ready   = 1'b1;
               cmd.capture = req_valid;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // After the execute state the controller always moves on to the scroll or done state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_SCROLL || state_ff == ST_DONE))
      else $error("tcw_ctrl: execute state did not hand over");

   // A captured request is executed in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC))
      else $error("tcw_ctrl: captured request not executed");

endmodule

FILE: design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console cell writer datapath
// Cell memory, cursor tracking, sweep counter and response register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   input  tcw_cmd_type        cmd,
   output tcw_status_type     status,
   input  logic               req_action,
   input  logic [CHAR_W-1:0]  req_char_code,
   input  logic [CHAR_W-1:0]  req_attr_byte,
   input  logic [INDEX_W-1:0] req_cell_index,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [INDEX_W-1:0] rsp_cursor_pos,
   output logic [CHAR_W-1:0]  rsp_cell_char,
   output logic [CHAR_W-1:0]  rsp_cell_attr,
   output logic               rsp_scrolled
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int CELL_W = $clog2(CELLS);
   localparam int POS_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int DATA_W = 2 * CHAR_W;

   localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELLS - 1);
   localparam logic [CELL_W-1:0] LAST_ROW   = CELL_W'(CELLS - COLUMNS);
   localparam logic [CELL_W-1:0] COLS_CELL  = CELL_W'(COLUMNS);
   localparam logic [POS_W-1:0]  COLS_POS   = POS_W'(COLUMNS);
   localparam logic [POS_W-1:0]  CELLS_POS  = POS_W'(CELLS);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
   localparam logic [DATA_W-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

   // Captured request.
   logic               action_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [CHAR_W-1:0]  attr_ff;
   logic [INDEX_W-1:0] index_ff;

   // Cursor kept as row start plus column, with the linear position alongside.
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [CELL_W-1:0] row_base_ff, row_base_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              scr_ff;

   // Sweep counter shared by the clearing pass and the scroll.
   logic [CELL_W-1:0] cnt_ff;

   // Memory and its pending scroll write.
   logic [DATA_W-1:0] cell_mem_ff [CELLS];
   logic [DATA_W-1:0] rd_data_ff;
   logic              wr_pend_ff;
   logic [CELL_W-1:0] wr_addr_ff;
   logic              wr_blank_ff;

   // Response register.
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_cursor_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic [CHAR_W-1:0]  rsp_attr_ff;
   logic               rsp_scr_ff;

   logic              is_put;
   logic              is_newline;
   logic              is_backspace;
   logic              index_ok;
   logic              scroll_reads;
   logic [POS_W-1:0]  nrb_pos;
   logic [CELL_W-1:0] npos;
   logic              wrap;
   logic              mem_we;
   logic [CELL_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_re;
   logic [CELL_W-1:0] mem_raddr;

   assign is_put       = (action_ff == ACT_PUT);
   assign is_newline   = (char_ff == CH_NEWLINE);
   assign is_backspace = (char_ff == CH_BACKSPACE);
   assign index_ok     = (32'(index_ff) < 32'(CELLS));
   assign scroll_reads = (cnt_ff < LAST_ROW);

   // Next cursor for a put request.
   always_comb begin
      nrb_pos = POS_W'(row_base_ff);
      npos    = cursor_ff;
      col_in  = col_ff;
      if (is_newline) begin
         nrb_pos = POS_W'(row_base_ff) + COLS_POS;
         npos    = CELL_W'(nrb_pos);
         col_in  = '0;
      end else if (is_backspace) begin
         if (cursor_ff == '0) begin
            npos   = CELL_W'(LAST_COL);
            col_in = LAST_COL;
         end else if (col_ff == '0) begin
            npos    = cursor_ff - CELL_W'(1);
            col_in  = LAST_COL;
            nrb_pos = POS_W'(row_base_ff - COLS_CELL);
         end else begin
            npos   = cursor_ff - CELL_W'(1);
            col_in = col_ff - COL_W'(1);
         end
      end else begin
         npos = CELL_W'(POS_W'(cursor_ff) + POS_W'(1));
         if (col_ff == LAST_COL) begin
            col_in  = '0;
            nrb_pos = POS_W'(row_base_ff) + COLS_POS;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      wrap        = is_put && (nrb_pos == CELLS_POS);
      cursor_in   = wrap ? LAST_ROW : npos;
      row_base_in = wrap ? LAST_ROW : CELL_W'(nrb_pos);
      if (wrap) col_in = '0;
   end

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = wr_blank_ff ? BLANK_CELL : rd_data_ff;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff;
         mem_wdata = '0;
      end else if (cmd.exec && is_put && !is_newline) begin
         mem_we    = 1'b1;
         mem_waddr = is_backspace ? npos : cursor_ff;
         mem_wdata = is_backspace ? BLANK_CELL : {attr_ff, char_ff};
      end else if (wr_pend_ff) begin
         mem_we = 1'b1;
      end
      mem_re    = 1'b0;
      mem_raddr = cnt_ff + COLS_CELL;
      if (cmd.exec && !is_put && index_ok) begin
         mem_re    = 1'b1;
         mem_raddr = CELL_W'(index_ff);
      end else if (cmd.scroll_step && scroll_reads) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= cell_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= cnt_ff;
      wr_blank_ff <= !scroll_reads;
      if (cmd.capture) begin
         action_ff <= req_action;
         char_ff   <= req_char_code;
         attr_ff   <= req_attr_byte;
         index_ff  <= req_cell_index;
      end
      if (cmd.finish) begin
         rsp_cursor_ff <= INDEX_W'(cursor_ff);
         rsp_char_ff   <= (!is_put && index_ok) ? rd_data_ff[CHAR_W-1:0] : '0;
         rsp_attr_ff   <= (!is_put && index_ok) ? rd_data_ff[DATA_W-1:CHAR_W] : '0;
         rsp_scr_ff    <= scr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         row_base_ff  <= '0;
         col_ff       <= '0;
         scr_ff       <= 1'b0;
         cnt_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.scroll_step;
         if (cmd.clear_step || cmd.scroll_step) begin
            cnt_ff <= (cnt_ff == LAST_CELL) ? '0 : cnt_ff + CELL_W'(1);
         end
         if (cmd.exec) begin
            scr_ff <= wrap;
            if (is_put) begin
               cursor_ff   <= cursor_in;
               row_base_ff <= row_base_in;
               col_ff      <= col_in;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.wrap       = cmd.exec && wrap;
   assign status.count_last = (cnt_ff == LAST_CELL);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   // The linear cursor always equals its row start plus its column.
   assert property (@(posedge clock) disable iff (reset)
      int'(cursor_ff) == int'(row_base_ff) + int'(col_ff))
      else $error("tcw_datapath: cursor and row/column disagree");

   // The cursor never leaves the screen.
   assert property (@(posedge clock) disable iff (reset)
      (int'(cursor_ff) < CELLS) && (int'(col_ff) < COLUMNS))
      else $error("tcw_datapath: cursor out of range");

   // A scroll leaves the cursor at the start of the bottom row.
   assert property (@(posedge clock) disable iff (reset)
      status.wrap |=> (cursor_ff == LAST_ROW && scr_ff))
      else $error("tcw_datapath: scroll did not park the cursor");

endmodule

FILE: design/text_console_cell_writer_core.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// Character-cell console engine with a linear cursor and a scrolling store.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_chan and every request yields exactly one
// response on rsp_chan; both are valid/ready channels, and a transfer happens
// on a clock edge where valid and ready are both high. A put request writes
// one character (a newline only moves the cursor, a backspace steps it back
// and blanks that cell); a read returns one stored cell with the cursor.
// After reset the block sweeps the cell memory to zero, one cell per cycle,
// over all ROWS*COLUMNS cells (2000 at 80x25); ready stays low meanwhile.
// A request is handled in the cycle after it is accepted, and its response
// is registered in the done state once the output register is free; a new
// request is only accepted once that response is registered, so the block
// works on one request at a time.
// A put that runs past the bottom row scrolls the screen:
// the memory is walked once, one cell per cycle, to move each row up one.
// The response sits in an output register; the next request is accepted
// while it waits, but that request's response is held back until the
// receiver takes the earlier one.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core import tcw_pkg::*; #(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);

   // Command and status links between the controller and the datapath.
   tcw_cmd_type    cmd;
   tcw_status_type status;

   // The controller owns the request handshake and the sequencing.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the cell memory, the cursor and the response register.
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_chan.action),
      .req_char_code  (req_chan.char_code),
      .req_attr_byte  (req_chan.attr_byte),
      .req_cell_index (req_chan.cell_index),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_cursor_pos (rsp_chan.cursor_pos),
      .rsp_cell_char  (rsp_chan.cell_char),
      .rsp_cell_attr  (rsp_chan.cell_attr),
      .rsp_scrolled   (rsp_chan.scrolled)
   );

endmodule
